[rtl/core/binary_min_heap_queue_unit_defines.svh]
`ifndef BINARY_MIN_HEAP_QUEUE_UNIT_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_UNIT_DEFINES_SVH

// checked on every rising clock edge out of reset
`define BHQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define BHQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/core/bhq_pkg.sv]
`default_nettype none

package bhq_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 6;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic                       command;
        logic signed [VALUE_W-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  min_value;
        t_status                    status;
        logic [COUNT_W-1:0]         count;
    } t_out_item;

    // operation broadcast to every cell of the row
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_cmd;

endpackage

`default_nettype wire

[rtl/core/binary_min_heap_queue_unit.sv]
`default_nettype none
// Priority queue holding up to CAPACITY signed keys, smallest key out first.
// Input channel (i_in_valid / o_in_ready / i_in_item): command insert puts
// value into the queue, command delete removes and returns the smallest key.
// Output channel (o_out_valid / i_out_ready / o_out_item): exactly one result
// per input transaction, in order: min_value (removed key, else zero), status
// (ok, full with the insert dropped, or empty) and the key count afterwards.
// Keys live in a row of CAPACITY cells kept sorted, smallest in cell 0; every
// cell compares against the incoming key and shifts toward its neighbor in
// the same cycle, so the whole row is updated together.
// The result appears in the output register in the cycle after the input
// transaction. Throughput: one transaction per cycle while the receiver
// keeps the output register drained.
// A stalled receiver holds the output register; a new input transaction is
// taken only in a cycle where the output register is empty or being drained.
// Reset empties the queue (all cells invalid, count zero) and clears the
// output valid; it is usable in the first cycle after reset.
`include "binary_min_heap_queue_unit_defines.svh"

module binary_min_heap_queue_unit
    import bhq_pkg::*;
#(
    parameter int CAPACITY  = 32,
    parameter int KEY_WIDTH = 32
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output t_out_item  o_out_item
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_out_item        r_out_item;
    t_out_item        n_out_item;

    logic             w_in_fire;
    logic             w_full;
    logic             w_empty;
    t_cell_cmd        w_cmd;

    logic signed [63:0]          w_value_wide;
    logic signed [63:0]          w_min_wide;
    logic signed [KEY_WIDTH-1:0] w_new_key;

    logic signed [KEY_WIDTH-1:0] w_key [CAPACITY];
    logic [CAPACITY-1:0]         w_valid;
    logic [CAPACITY-1:0]         w_lt;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign w_full  = (r_count == CNT_W'(CAPACITY));
    assign w_empty = (r_count == '0);

    assign w_cmd.ins = w_in_fire && (i_in_item.command == CMD_INSERT) && !w_full;
    assign w_cmd.del = w_in_fire && (i_in_item.command == CMD_DELETE) && !w_empty;

    // key arrives as 32 bits, sign extended or truncated to the key width
    assign w_value_wide = 64'(i_in_item.value);
    assign w_new_key    = w_value_wide[KEY_WIDTH-1:0];
    assign w_min_wide   = 64'(w_key[0]);

    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [KEY_WIDTH-1:0] w_prev_key;
            logic                        w_prev_valid;
            logic                        w_prev_lt;
            logic signed [KEY_WIDTH-1:0] w_next_key;
            logic                        w_next_valid;

            if (g == 0) begin : g_head
                assign w_prev_key   = w_new_key;
                assign w_prev_valid = 1'b1;
                assign w_prev_lt    = 1'b0;
            end else begin : g_body
                assign w_prev_key   = w_key[g-1];
                assign w_prev_valid = w_valid[g-1];
                assign w_prev_lt    = w_lt[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign w_next_key   = w_new_key;
                assign w_next_valid = 1'b0;
            end else begin : g_link
                assign w_next_key   = w_key[g+1];
                assign w_next_valid = w_valid[g+1];
            end

            bhq_cell #(
                .KEY_WIDTH (KEY_WIDTH)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmd        (w_cmd),
                .i_new_key    (w_new_key),
                .i_prev_key   (w_prev_key),
                .i_prev_valid (w_prev_valid),
                .i_prev_lt    (w_prev_lt),
                .i_next_key   (w_next_key),
                .i_next_valid (w_next_valid),
                .o_key        (w_key[g]),
                .o_valid      (w_valid[g]),
                .o_lt         (w_lt[g])
            );
        end
    endgenerate

    always_comb begin
        n_count              = r_count;
        n_out_item.min_value = '0;
        n_out_item.status    = STATUS_OK;
        case (i_in_item.command)
            CMD_INSERT: begin
                if (w_full) begin
                    n_out_item.status = STATUS_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_DELETE: begin
                if (w_empty) begin
                    n_out_item.status = STATUS_EMPTY;
                end else begin
                    n_count              = r_count - CNT_W'(1);
                    n_out_item.min_value = w_min_wide[VALUE_W-1:0];
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_out_item.count = COUNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_out_item <= n_out_item;
        end
    end

    `BHQ_ASSERT(a_count_in_range, r_count <= CNT_W'(CAPACITY), "count above capacity")
    `BHQ_ASSERT(a_cells_match_count, $countones(w_valid) == int'(r_count), "valid vs count")
    `BHQ_ASSERT(a_head_is_min, w_valid[1] |-> (w_key[0] <= w_key[1]), "row out of order")
    `BHQ_ASSERT(a_result_follows, w_in_fire |=> o_out_valid, "no result after transaction")
    `BHQ_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> w_empty && !o_out_valid, "reset not applied")

endmodule

`default_nettype wire

[rtl/core/bhq_cell.sv]
`default_nettype none

module bhq_cell
    import bhq_pkg::*;
#(
    parameter int KEY_WIDTH = 32
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  t_cell_cmd                   i_cmd,
    input  wire logic signed [KEY_WIDTH-1:0] i_new_key,
    input  wire logic signed [KEY_WIDTH-1:0] i_prev_key,
    input  wire                         i_prev_valid,
    input  wire                         i_prev_lt,
    input  wire logic signed [KEY_WIDTH-1:0] i_next_key,
    input  wire                         i_next_valid,
    output logic signed [KEY_WIDTH-1:0] o_key,
    output logic                        o_valid,
    output logic                        o_lt
);

    logic signed [KEY_WIDTH-1:0] r_key;
    logic                        r_valid;
    logic signed [KEY_WIDTH-1:0] n_key;
    logic                        n_valid;

    // new key belongs at or before this slot
    assign o_lt    = !r_valid || (i_new_key < r_key);
    assign o_key   = r_key;
    assign o_valid = r_valid;

    always_comb begin
        n_key   = r_key;
        n_valid = r_valid;
        if (i_cmd.ins) begin
            n_valid = r_valid || i_prev_valid;
            if (o_lt) begin
                // upstream slot is shifting down into us, else the new key lands here
                n_key = i_prev_lt ? i_prev_key : i_new_key;
            end
        end else if (i_cmd.del) begin
            n_key   = i_next_key;
            n_valid = i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

`default_nettype wire
